FILE: src/rid_pkg.sv
// Shared types and constants for the integer divider.
package rid_pkg;

  localparam int unsigned XLEN_DEF = 64;
  localparam int unsigned QBITS_DEF = 8;

  localparam logic [1:0] OP_DIV  = 2'd0;
  localparam logic [1:0] OP_DIVU = 2'd1;
  localparam logic [1:0] OP_REM  = 2'd2;
  localparam logic [1:0] OP_REMU = 2'd3;

  // Per-request control that travels along the cell chain.
  typedef struct packed {
    logic is_rem;
    logic word;
    logic negate;
    logic zero_div;
    logic overflow;
  } ctrl_t;

endpackage

FILE: src/rid_if.sv
// Valid/ready channel interfaces for requests and results.
interface rid_req_if #(parameter int unsigned W = 64);
  logic         valid;
  logic         ready;
  logic [1:0]   operation;
  logic         word_mode;
  logic [W-1:0] dividend;
  logic [W-1:0] divisor;
  modport source (output valid, operation, word_mode, dividend, divisor, input ready);
  modport sink   (input valid, operation, word_mode, dividend, divisor, output ready);
endinterface

interface rid_rsp_if #(parameter int unsigned W = 64);
  logic         valid;
  logic         ready;
  logic [W-1:0] result;
  modport source (output valid, result, input ready);
  modport sink   (input valid, result, output ready);
endinterface

FILE: src/rid_cell.sv
// One divider cell: QB restoring steps on the held operands, then registered.
module rid_cell #(
  parameter int unsigned W  = 64,
  parameter int unsigned QB = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           vld_in,
  input  rid_pkg::ctrl_t ctl_in,
  input  logic [W-1:0]   rem_in,
  input  logic [W-1:0]   num_in,
  input  logic [W-1:0]   den_in,
  output logic           vld_r,
  output rid_pkg::ctrl_t ctl_r,
  output logic [W-1:0]   rem_r,
  output logic [W-1:0]   num_r,
  output logic [W-1:0]   den_r
);

  logic [W-1:0] rem_nxt;
  logic [W-1:0] num_nxt;

  // num carries the remaining dividend bits at the top and quotient bits at the bottom
  always_comb begin
    logic [W:0] t;
    rem_nxt = rem_in;
    num_nxt = num_in;
    for (int s = 0; s < QB; s++) begin
      t = {rem_nxt, num_nxt[W-1]};
      num_nxt = {num_nxt[W-2:0], 1'b0};
      if (t >= {1'b0, den_in}) begin
        t = t - {1'b0, den_in};
        num_nxt[0] = 1'b1;
      end
      rem_nxt = t[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl_r <= ctl_in;
      rem_r <= rem_nxt;
      num_r <= num_nxt;
      den_r <= den_in;
    end
  end

endmodule

FILE: src/riscv_integer_divider.sv
// Register stages: an input stage, one cell per group of quotient bits, and an output stage.
// Throughput: one request per cycle; the chain of cells advances in lockstep and
//   stalls as a whole only while the output register is full and not taken.
// Word-mode requests pass the full chain with operands placed in the low bits.
// Reset (rst_n, synchronous, active low) clears every valid bit; data is left as is.
module riscv_integer_divider #(
  parameter int unsigned XLEN = rid_pkg::XLEN_DEF,
  parameter int unsigned QUOTIENT_BITS_PER_STEP = rid_pkg::QBITS_DEF
) (
  input logic clk,
  input logic rst_n,
  rid_req_if.sink   in_req,
  rid_rsp_if.source out_rsp
);

  localparam int unsigned NC = (XLEN + QUOTIENT_BITS_PER_STEP - 1) / QUOTIENT_BITS_PER_STEP;
  localparam int unsigned W  = NC * QUOTIENT_BITS_PER_STEP;

  logic adv;
  logic out_valid_r;
  logic [XLEN-1:0] out_result_r;
  assign adv = !out_valid_r || out_rsp.ready;
  assign in_req.ready = adv;

  // decode and take magnitudes
  logic          is_signed, is_rem, word;
  logic [XLEN-1:0] mask, minv, a, b, ma, mb;
  logic          sa, sb;
  rid_pkg::ctrl_t c_nxt;
  always_comb begin
    is_signed = !in_req.operation[0];
    is_rem    = in_req.operation[1];
    word      = in_req.word_mode && (XLEN > 32);
    mask      = word ? XLEN'(33'h0_FFFF_FFFF) : '1;
    minv      = word ? XLEN'(33'h0_8000_0000) : {1'b1, {(XLEN-1){1'b0}}};
    a  = in_req.dividend & mask;
    b  = in_req.divisor & mask;
    sa = is_signed && ((a & minv) != '0);
    sb = is_signed && ((b & minv) != '0);
    ma = sa ? ((~a + 1'b1) & mask) : a;
    mb = sb ? ((~b + 1'b1) & mask) : b;
    c_nxt.is_rem   = is_rem;
    c_nxt.word     = word;
    c_nxt.negate   = is_rem ? sa : (sa != sb);
    c_nxt.zero_div = (b == '0);
    c_nxt.overflow = is_signed && (a == minv) && (b == mask);
  end

  logic            s0_vld_r;
  rid_pkg::ctrl_t  s0_ctl_r;
  logic [W-1:0]    s0_num_r, s0_den_r;
  logic [XLEN-1:0] s0_raw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (adv) begin
      s0_vld_r <= in_req.valid;
    end
  end

  // word operands are zero above bit 31, so the full chain yields the 32-bit quotient
  always_ff @(posedge clk) begin
    if (adv) begin
      s0_ctl_r <= c_nxt;
      s0_num_r <= W'(ma);
      s0_den_r <= W'(mb);
      s0_raw_r <= a;
    end
  end

  logic           vld [NC+1];
  rid_pkg::ctrl_t ctl [NC+1];
  logic [W-1:0]   rem [NC+1];
  logic [W-1:0]   num [NC+1];
  logic [W-1:0]   den [NC+1];
  logic [XLEN-1:0] raw [NC+1];

  assign vld[0] = s0_vld_r;
  assign ctl[0] = s0_ctl_r;
  assign rem[0] = '0;
  assign num[0] = s0_num_r;
  assign den[0] = s0_den_r;
  assign raw[0] = s0_raw_r;

  for (genvar g = 0; g < NC; g++) begin : g_cell
    rid_cell #(.W(W), .QB(QUOTIENT_BITS_PER_STEP)) u_cell (
      .clk(clk), .rst_n(rst_n), .adv(adv),
      .vld_in(vld[g]), .ctl_in(ctl[g]), .rem_in(rem[g]), .num_in(num[g]), .den_in(den[g]),
      .vld_r(vld[g+1]), .ctl_r(ctl[g+1]), .rem_r(rem[g+1]), .num_r(num[g+1]),
      .den_r(den[g+1])
    );
    always_ff @(posedge clk) begin
      if (adv) begin
        raw[g+1] <= raw[g];
      end
    end
  end

  // fix up signs and special cases
  logic [XLEN-1:0] res, fmask, fminv, q_f, r_f;
  rid_pkg::ctrl_t  cf;
  always_comb begin
    cf    = ctl[NC];
    fmask = cf.word ? XLEN'(33'h0_FFFF_FFFF) : '1;
    fminv = cf.word ? XLEN'(33'h0_8000_0000) : {1'b1, {(XLEN-1){1'b0}}};
    q_f   = num[NC][XLEN-1:0] & fmask;
    r_f   = rem[NC][XLEN-1:0] & fmask;
    if (cf.zero_div) begin
      res = cf.is_rem ? raw[NC] : fmask;
    end else if (cf.overflow) begin
      res = cf.is_rem ? '0 : fminv;
    end else begin
      res = cf.is_rem ? r_f : q_f;
      if (cf.negate) res = (~res + 1'b1) & fmask;
    end
    if (cf.word && res[31]) res = res | ~fmask;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld[NC];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_result_r <= res;
    end
  end

  assign out_rsp.valid  = out_valid_r;
  assign out_rsp.result = out_result_r;

`ifndef SYNTH
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_rsp.ready |=> out_valid_r && $stable(out_result_r))
    else $error("result changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.ready == (!out_valid_r || out_rsp.ready))
    else $error("ready does not follow output register");
  a_chain: assert property (@(posedge clk) disable iff (!rst_n)
    adv && vld[NC] |=> out_valid_r)
    else $error("result lost at chain exit");
`endif

endmodule
